@@ design/drls_pkg.sv @@
// Package: shared types, constants and lookup tables of the dice LED scanner.
`timescale 1ns / 1ps

package drls_pkg;

    // Field and state widths
    localparam int unsigned ANIM_TICKS_W  = 16;
    localparam int unsigned SLEEP_TICKS_W = 24;
    localparam int unsigned CFG_DATA_W    = 24;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam int unsigned ROLL_W        = 3;
    localparam int unsigned SCAN_W        = 3;
    localparam int unsigned FRAME_W       = 4;
    localparam int unsigned FACE_W        = 7;
    localparam int unsigned PIN_W         = 8;

    // Request operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_TICKS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_TICKS = 1'b1;

    // Reset values
    localparam logic [ANIM_TICKS_W-1:0]  ANIM_TICKS_RST  = 16'd937;
    localparam logic [SLEEP_TICKS_W-1:0] SLEEP_TICKS_RST = 24'd562500;
    localparam logic [FACE_W-1:0]        FACE_RST        = 7'h7F;

    // Counter limits
    localparam logic [ROLL_W-1:0]        ROLL_LAST  = 3'd5;
    localparam logic [SCAN_W-1:0]        SCAN_LAST  = 3'd6;
    localparam logic [FRAME_W-1:0]       ANIM_LAST  = 4'd8;
    localparam logic [SLEEP_TICKS_W-1:0] IDLE_MAX   = 24'hFFFFFF;

    // Pin bytes while asleep: all lines inputs, pull-up kept
    localparam logic [PIN_W-1:0] SLEEP_DIR  = 8'h00;
    localparam logic [PIN_W-1:0] PULLUP_LVL = 8'h01;

    // One result request
    typedef struct packed {
        logic [PIN_W-1:0]  pin_direction;
        logic [PIN_W-1:0]  pin_level;
        logic              asleep;
        logic [FACE_W-1:0] face_pattern;
    } result_t;

    // Face pattern for a roll count; unused codes give the first face
    function automatic logic [FACE_W-1:0] face_lookup(input logic [ROLL_W-1:0] roll);
        logic [FACE_W-1:0] pat;
        case (roll)
            3'd1:    pat = 7'h41;
            3'd2:    pat = 7'h2A;
            3'd3:    pat = 7'h63;
            3'd4:    pat = 7'h6B;
            3'd5:    pat = 7'h77;
            default: pat = 7'h08;
        endcase
        return pat;
    endfunction

    // Animation frame pattern
    function automatic logic [FACE_W-1:0] anim_lookup(input logic [FRAME_W-1:0] frame);
        logic [FACE_W-1:0] pat;
        case (frame)
            4'd1:    pat = 7'h02;
            4'd2:    pat = 7'h10;
            4'd3:    pat = 7'h40;
            4'd5:    pat = 7'h01;
            4'd6:    pat = 7'h04;
            4'd7:    pat = 7'h20;
            default: pat = 7'h08;
        endcase
        return pat;
    endfunction

    // Direction byte that lights one LED
    function automatic logic [PIN_W-1:0] led_dir(input logic [SCAN_W-1:0] idx);
        logic [PIN_W-1:0] d;
        case (idx)
            3'd0:    d = 8'h14;
            3'd1:    d = 8'h0A;
            3'd2:    d = 8'h18;
            3'd3:    d = 8'h0A;
            3'd4:    d = 8'h06;
            3'd5:    d = 8'h18;
            3'd6:    d = 8'h06;
            default: d = 8'h00;
        endcase
        return d;
    endfunction

    // Level byte that lights one LED
    function automatic logic [PIN_W-1:0] led_lvl(input logic [SCAN_W-1:0] idx);
        logic [PIN_W-1:0] l;
        case (idx)
            3'd0:    l = 8'h04;
            3'd1:    l = 8'h08;
            3'd2:    l = 8'h10;
            3'd3:    l = 8'h02;
            3'd4:    l = 8'h04;
            3'd5:    l = 8'h08;
            3'd6:    l = 8'h02;
            default: l = 8'h00;
        endcase
        return l;
    endfunction

endpackage

@@ design/drls_core.sv @@
// Dice state, configuration registers and the combinational update per request.
`timescale 1ns / 1ps

module drls_core
    import drls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  op,
    input  logic                  button_pressed,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output result_t               result
);

    logic [ANIM_TICKS_W-1:0]  anim_ticks_reg;
    logic [SLEEP_TICKS_W-1:0] sleep_ticks_reg;

    logic [ROLL_W-1:0]        roll_reg,   roll_next;
    logic [SCAN_W-1:0]        scan_reg,   scan_next;
    logic [FACE_W-1:0]        face_reg,   face_next;
    logic [FRAME_W-1:0]       frame_reg,  frame_next;
    logic [ANIM_TICKS_W-1:0]  timer_reg,  timer_next;
    logic                     anim_reg,   anim_next;
    logic [SLEEP_TICKS_W-1:0] idle_reg,   idle_next;
    logic                     sleep_reg,  sleep_next;
    logic [PIN_W-1:0]         dir_reg,    dir_next;
    logic [PIN_W-1:0]         lvl_reg,    lvl_next;

    logic [FRAME_W-1:0]       frame_cur;
    logic [ANIM_TICKS_W-1:0]  timer_cur;
    logic [FRAME_W-1:0]       frame_inc;
    logic [FACE_W-1:0]        shown;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anim_ticks_reg  <= ANIM_TICKS_RST;
            sleep_ticks_reg <= SLEEP_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ANIM_TICKS:  anim_ticks_reg  <= cfg_data[ANIM_TICKS_W-1:0];
                CFG_SLEEP_TICKS: sleep_ticks_reg <= cfg_data[SLEEP_TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // Work out the next state for the request
    always_comb
    begin
        roll_next  = roll_reg;
        scan_next  = scan_reg;
        face_next  = face_reg;
        frame_next = frame_reg;
        timer_next = timer_reg;
        anim_next  = anim_reg;
        idle_next  = idle_reg;
        sleep_next = sleep_reg;
        dir_next   = dir_reg;
        lvl_next   = lvl_reg;

        // A finished animation restarts from the first frame
        frame_cur = (frame_reg > ANIM_LAST) ? '0 : frame_reg;
        timer_cur = (frame_reg > ANIM_LAST) ? '0 : timer_reg;
        frame_inc = frame_cur + 1'b1;
        shown     = face_reg;

        if (op == OP_TICK)
        begin
            if (sleep_reg)
            begin
                // hold everything while asleep
            end
            else if (idle_reg >= sleep_ticks_reg)
            begin
                sleep_next = 1'b1;
                dir_next   = SLEEP_DIR;
                lvl_next   = PULLUP_LVL;
            end
            else
            begin
                roll_next = (roll_reg >= ROLL_LAST) ? '0 : roll_reg + 1'b1;
                scan_next = (scan_reg >= SCAN_LAST) ? '0 : scan_reg + 1'b1;

                // Advance the animation or show the latched face
                if ((frame_reg <= ANIM_LAST || button_pressed) && anim_reg)
                begin
                    shown = anim_lookup(frame_cur);
                    if (timer_cur >= anim_ticks_reg)
                    begin
                        timer_next = '0;
                        frame_next = (frame_inc >= ANIM_LAST && button_pressed)
                                     ? '0 : frame_inc;
                    end
                    else
                    begin
                        timer_next = timer_cur + 1'b1;
                        frame_next = frame_cur;
                    end
                end

                // Drive the scanned LED
                if (shown[scan_next])
                begin
                    dir_next = led_dir(scan_next);
                    lvl_next = led_lvl(scan_next) | PULLUP_LVL;
                end
                else
                begin
                    dir_next = SLEEP_DIR;
                    lvl_next = PULLUP_LVL;
                end

                // Count idle ticks, saturating
                if (idle_reg != IDLE_MAX)
                    idle_next = idle_reg + 1'b1;
                if (idle_next >= sleep_ticks_reg)
                begin
                    sleep_next = 1'b1;
                    dir_next   = SLEEP_DIR;
                    lvl_next   = PULLUP_LVL;
                end
            end
        end
        else
        begin
            if (sleep_reg)
            begin
                // wake only, animation off
                anim_next = 1'b0;
                if (button_pressed)
                begin
                    idle_next  = '0;
                    sleep_next = 1'b0;
                end
            end
            else if (button_pressed)
            begin
                face_next = face_lookup(roll_reg);
                idle_next = '0;
                anim_next = 1'b1;
            end
        end
    end

    // Hold state, advance on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_reg  <= '0;
            scan_reg  <= '0;
            face_reg  <= FACE_RST;
            frame_reg <= '0;
            timer_reg <= '0;
            anim_reg  <= 1'b1;
            idle_reg  <= '0;
            sleep_reg <= 1'b0;
            dir_reg   <= '0;
            lvl_reg   <= '0;
        end
        else if (accept)
        begin
            roll_reg  <= roll_next;
            scan_reg  <= scan_next;
            face_reg  <= face_next;
            frame_reg <= frame_next;
            timer_reg <= timer_next;
            anim_reg  <= anim_next;
            idle_reg  <= idle_next;
            sleep_reg <= sleep_next;
            dir_reg   <= dir_next;
            lvl_reg   <= lvl_next;
        end
    end

    // Result of the request follows from the updated state
    always_comb
    begin
        result.pin_direction = dir_next;
        result.pin_level     = lvl_next;
        result.asleep        = sleep_next;
        result.face_pattern  = face_next;
    end

endmodule

@@ design/drls_out.sv @@
// Result register between the update logic and the output channel.
`timescale 1ns / 1ps

module drls_out
    import drls_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    input  logic    out_stall,
    output logic    out_valid,
    output logic    full,
    output result_t data
);

    logic    valid_reg;
    result_t data_reg;

    // Track whether a result request is waiting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign out_valid = valid_reg;
    assign full      = valid_reg && out_stall;
    assign data      = data_reg;

endmodule

@@ design/dice_roller_led_scanner.sv @@
// Top level of the electronic dice with charlieplexed LED scanning.
`timescale 1ns / 1ps

// Electronic dice with a seven-LED charlieplexed display. Each input request
// is a timer tick or a button event and yields exactly one result request
// carrying the pin direction and level bytes, the sleep flag and the latched
// face pattern. The whole update is combinational between the state
// registers and a single result register, so one request is taken every
// clock unless stalled; its result shows the next cycle. The input is stalled
// only while the result register is full and the output side is stalling.
// Configuration (index 0: animation tick count, index 1: sleep tick count) is
// always ready and is meant to be written while the block is idle.
module dice_roller_led_scanner
    import drls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic                  button_pressed,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIN_W-1:0]      pin_direction,
    output logic [PIN_W-1:0]      pin_level,
    output logic                  asleep,
    output logic [FACE_W-1:0]     face_pattern,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic    accept;
    logic    out_full;
    result_t result;
    result_t out_data;

    // Take a request whenever the result register can be refilled
    assign in_stall  = out_full;
    assign accept    = in_valid && !out_full;
    assign cfg_ready = 1'b1;

    drls_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .op             (op),
        .button_pressed (button_pressed),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result         (result)
    );

    drls_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .result    (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .full      (out_full),
        .data      (out_data)
    );

    assign pin_direction = out_data.pin_direction;
    assign pin_level     = out_data.pin_level;
    assign asleep        = out_data.asleep;
    assign face_pattern  = out_data.face_pattern;

endmodule

@@ verif/tb_dice_roller_led_scanner.sv @@
// Testbench for the dice LED scanner: drives tick and button requests and checks every result.
`timescale 1ns / 1ps

module tb_dice_roller_led_scanner;
    import drls_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam int unsigned PHASE_ITEMS    = 250;
    localparam int unsigned RX_HOLD_CYCLES = 200;

    // Lookup tables of the dice, element 0 rightmost
    localparam logic [5:0][FACE_W-1:0] FACE_PATTERNS =
        {7'h77, 7'h6B, 7'h63, 7'h2A, 7'h41, 7'h08};
    localparam logic [8:0][FACE_W-1:0] SPIN_FRAMES =
        {7'h08, 7'h20, 7'h04, 7'h01, 7'h08, 7'h40, 7'h10, 7'h02, 7'h08};
    localparam logic [6:0][PIN_W-1:0] LED_DIR_BYTES =
        {8'h06, 8'h18, 8'h06, 8'h0A, 8'h18, 8'h0A, 8'h14};
    localparam logic [6:0][PIN_W-1:0] LED_LVL_BYTES =
        {8'h02, 8'h08, 8'h04, 8'h02, 8'h10, 8'h08, 8'h04};

    typedef struct packed {
        logic op;
        logic held;
    } dice_req_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic                  op             = OP_TICK;
    logic                  button_pressed = 1'b0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic [PIN_W-1:0]      pin_direction;
    logic [PIN_W-1:0]      pin_level;
    logic                  asleep;
    logic [FACE_W-1:0]     face_pattern;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = CFG_ANIM_TICKS;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    // Stimulus and scoreboard storage
    dice_req_t pending_reqs_q[$];
    result_t   pins_expected_q[$];
    int unsigned mismatch_count = 0;
    int unsigned stuck_cycles   = 0;
    int unsigned tx_idle_pct    = 10;
    int unsigned rx_stall_pct   = 54;
    int unsigned rx_hold_left   = 0;
    logic        rx_hold_trigger = 1'b0;
    logic        rx_hold_done    = 1'b0;
    logic        tx_pause       = 1'b0;
    logic        req_taken      = 1'b0;

    // Mirror of the dice state and its registers
    logic [ANIM_TICKS_W-1:0]  m_anim_ticks  = ANIM_TICKS_RST;
    logic [SLEEP_TICKS_W-1:0] m_sleep_ticks = SLEEP_TICKS_RST;
    logic [ROLL_W-1:0]        m_roll        = '0;
    logic [SCAN_W-1:0]        m_scan        = '0;
    logic [FACE_W-1:0]        m_face        = 7'h7F;
    logic [FRAME_W-1:0]       m_frame       = '0;
    logic [ANIM_TICKS_W-1:0]  m_frame_timer = '0;
    logic                     m_anim_on     = 1'b1;
    logic [SLEEP_TICKS_W-1:0] m_idle        = '0;
    logic                     m_sleeping    = 1'b0;
    logic [PIN_W-1:0]         m_dir         = '0;
    logic [PIN_W-1:0]         m_lvl         = '0;

    dice_roller_led_scanner dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .button_pressed (button_pressed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pin_direction  (pin_direction),
        .pin_level      (pin_level),
        .asleep         (asleep),
        .face_pattern   (face_pattern),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    // Enter sleep: all lines inputs, pull-up kept
    function automatic void doze_off();
        m_sleeping = 1'b1;
        m_dir      = SLEEP_DIR;
        m_lvl      = PULLUP_LVL;
    endfunction

    // Advance the mirrored dice by one request and return the pins it should show
    function automatic result_t dice_pins_after(input logic req_op, input logic held);
        logic [FACE_W-1:0] shown;
        result_t           r;
        if (req_op == OP_TICK)
        begin
            if (!m_sleeping)
            begin
                if (m_idle >= m_sleep_ticks)
                begin
                    doze_off();
                end
                else
                begin
                    m_roll = (m_roll >= ROLL_LAST) ? '0 : m_roll + 1'b1;
                    m_scan = (m_scan >= SCAN_LAST) ? '0 : m_scan + 1'b1;
                    if ((m_frame <= ANIM_LAST || held) && m_anim_on)
                    begin
                        // Restart a finished spin while the button is held
                        if (m_frame > ANIM_LAST)
                        begin
                            m_frame       = '0;
                            m_frame_timer = '0;
                        end
                        shown = SPIN_FRAMES[m_frame];
                        if (m_frame_timer >= m_anim_ticks)
                        begin
                            m_frame_timer = '0;
                            m_frame       = m_frame + 1'b1;
                            if (m_frame >= ANIM_LAST && held)
                                m_frame = '0;
                        end
                        else
                        begin
                            m_frame_timer = m_frame_timer + 1'b1;
                        end
                    end
                    else
                    begin
                        shown = m_face;
                    end
                    m_dir = SLEEP_DIR;
                    m_lvl = PULLUP_LVL;
                    if (shown[m_scan])
                    begin
                        m_dir = LED_DIR_BYTES[m_scan];
                        m_lvl = m_lvl | LED_LVL_BYTES[m_scan];
                    end
                    if (m_idle != IDLE_MAX)
                        m_idle = m_idle + 1'b1;
                    if (m_idle >= m_sleep_ticks)
                        doze_off();
                end
            end
        end
        else if (m_sleeping)
        begin
            // A button edge while asleep only wakes, without a new roll
            m_anim_on = 1'b0;
            if (held)
            begin
                m_idle     = '0;
                m_sleeping = 1'b0;
            end
        end
        else if (held)
        begin
            m_face    = FACE_PATTERNS[(m_roll > ROLL_LAST) ? '0 : m_roll];
            m_idle    = '0;
            m_anim_on = 1'b1;
        end
        r.pin_direction = m_dir;
        r.pin_level     = m_lvl;
        r.asleep        = m_sleeping;
        r.face_pattern  = m_face;
        return r;
    endfunction

    // Offer requests from the pending queue; hold a request until it is taken
    always @(negedge clk)
    begin
        dice_req_t req;
        if (rst_n && (!in_valid || req_taken))
        begin
            if (!tx_pause && pending_reqs_q.size() != 0 &&
                $urandom_range(99) >= tx_idle_pct)
            begin
                req = pending_reqs_q.pop_front();
                in_valid       <= 1'b1;
                op             <= req.op;
                button_pressed <= req.held;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random, or for a counted hold-off
    always @(negedge clk)
    begin
        if (rx_hold_trigger && !rx_hold_done)
        begin
            rx_hold_done = 1'b1;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left = rx_hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Observe handshakes, check results and predict accepted requests
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        logic    progress;
        progress = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                progress = 1'b1;
                case (cfg_index)
                    CFG_ANIM_TICKS:  m_anim_ticks  = cfg_data[ANIM_TICKS_W-1:0];
                    CFG_SLEEP_TICKS: m_sleep_ticks = cfg_data[SLEEP_TICKS_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                progress = 1'b1;
                got.pin_direction = pin_direction;
                got.pin_level     = pin_level;
                got.asleep        = asleep;
                got.face_pattern  = face_pattern;
                if (pins_expected_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: dir=%h lvl=%h asleep=%b face=%h",
                                 got.pin_direction, got.pin_level, got.asleep,
                                 got.face_pattern);
                end
                else
                begin
                    want = pins_expected_q.pop_front();
                    if (got.pin_direction !== want.pin_direction ||
                        got.pin_level !== want.pin_level ||
                        got.asleep !== want.asleep ||
                        got.face_pattern !== want.face_pattern)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"mismatch at %0t: exp dir=%h lvl=%h asleep=%b face=%h,",
                                      " got dir=%h lvl=%h asleep=%b face=%h"},
                                     $realtime, want.pin_direction, want.pin_level,
                                     want.asleep, want.face_pattern, got.pin_direction,
                                     got.pin_level, got.asleep, got.face_pattern);
                    end
                end
            end
            req_taken = in_valid && !in_stall;
            if (req_taken)
            begin
                progress = 1'b1;
                pins_expected_q.push_back(dice_pins_after(op, button_pressed));
            end
            // Abort when nothing moves for too long
            stuck_cycles = progress ? 0 : stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic queue_req(input logic req_op, input logic held);
        dice_req_t req;
        req.op   = req_op;
        req.held = held;
        pending_reqs_q.push_back(req);
    endtask

    // Queue press, hold, release and rest sequences with some noise mixed in
    task automatic queue_roll_sequences(input int unsigned count);
        int unsigned added;
        int unsigned hold_ticks;
        int unsigned rest_ticks;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(99) < 15)
            begin
                queue_req(1'($urandom_range(1)), 1'($urandom_range(1)));
                added++;
            end
            else
            begin
                hold_ticks = $urandom_range(12);
                rest_ticks = ($urandom_range(3) == 0) ? $urandom_range(150) : $urandom_range(40);
                queue_req(OP_PRESS, 1'b1);
                repeat (hold_ticks) queue_req(OP_TICK, 1'b1);
                queue_req(OP_PRESS, 1'b0);
                repeat (rest_ticks) queue_req(OP_TICK, 1'b0);
                added += hold_ticks + rest_ticks + 2;
            end
        end
    endtask

    // Wait until every request is taken and every result has arrived
    task automatic wait_drained();
        while (pending_reqs_q.size() != 0 || in_valid || pins_expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Power-up pins, release and press before the first tick, then ticks
        queue_req(OP_PRESS, 1'b0);
        queue_req(OP_PRESS, 1'b1);
        queue_req(OP_TICK, 1'b1);
        queue_req(OP_PRESS, 1'b0);
        queue_req(OP_TICK, 1'b0);
        queue_req(OP_TICK, 1'b0);
        wait_drained();

        // Frame every tick; reach the idle limit, then poke the sleeping dice
        write_reg(CFG_ANIM_TICKS, 24'd0);
        write_reg(CFG_SLEEP_TICKS, 24'd5);
        repeat (3) queue_req(OP_TICK, 1'b0);
        queue_req(OP_PRESS, 1'b0);
        queue_req(OP_PRESS, 1'b1);
        queue_req(OP_TICK, 1'b1);
        queue_req(OP_PRESS, 1'b0);
        wait_drained();

        // Run a whole spin to its rest frame
        write_reg(CFG_SLEEP_TICKS, 24'd30);
        queue_req(OP_PRESS, 1'b1);
        repeat (10) queue_req(OP_TICK, 1'b0);
        wait_drained();

        // Lower the idle limit below the count reached
        write_reg(CFG_SLEEP_TICKS, 24'd3);
        queue_req(OP_TICK, 1'b0);
        wait_drained();

        // Random phases over several register settings and idling modes
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(CFG_ANIM_TICKS, 24'd2);
                    write_reg(CFG_SLEEP_TICKS, 24'd40);
                end
                1:
                begin
                    write_reg(CFG_ANIM_TICKS, 24'd0);
                    write_reg(CFG_SLEEP_TICKS, 24'd1);
                end
                2:
                begin
                    tx_idle_pct  = 54;
                    rx_stall_pct = 10;
                    write_reg(CFG_ANIM_TICKS, 24'h00FFFF);
                    write_reg(CFG_SLEEP_TICKS, 24'hFFFFFF);
                end
                3:
                begin
                    write_reg(CFG_ANIM_TICKS, 24'($urandom_range(5, 1)));
                    write_reg(CFG_SLEEP_TICKS, 24'($urandom_range(120, 20)));
                end
                4:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    write_reg(CFG_ANIM_TICKS, 24'd1);
                    write_reg(CFG_SLEEP_TICKS, 24'($urandom_range(60, 10)));
                end
                default:
                begin
                    // Upper data bits are dropped by the 16-bit register
                    write_reg(CFG_ANIM_TICKS, {8'($urandom), 16'($urandom_range(7))});
                    write_reg(CFG_SLEEP_TICKS, 24'($urandom_range(200, 30)));
                end
            endcase
            queue_roll_sequences(PHASE_ITEMS / 2);
            if (phase == 0)
            begin
                // Hold off results while requests keep coming, to back up the input
                while (pending_reqs_q.size() != 0) @(posedge clk);
                rx_hold_trigger = 1'b1;
            end
            else if (phase == 3)
            begin
                // Pause the sender until every result is in
                while (pending_reqs_q.size() != 0) @(posedge clk);
                tx_pause = 1'b1;
                while (in_valid || pins_expected_q.size() != 0) @(posedge clk);
                tx_pause = 1'b0;
            end
            queue_roll_sequences(PHASE_ITEMS / 2);
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pins_expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
design/drls_pkg.sv
design/drls_core.sv
design/drls_out.sv
design/dice_roller_led_scanner.sv
verif/tb_dice_roller_led_scanner.sv
